// ===== hw/rtl/dpw_pkg.sv =====
// Shared types and constants of the alias-suppressed polynomial oscillator.
package dpw_pkg;

    localparam logic signed [63:0] Q_ONE   = 64'sh1000_0000_0000_0000;
    localparam logic signed [63:0] Q_HALF  = 64'sh0800_0000_0000_0000;
    localparam logic signed [63:0] Q_SIXTH = 64'sd192153584101141163;
    localparam logic signed [63:0] Q_THIRD = 64'sd384307168202282325;

    localparam logic [2:0] CFG_WAVE_TYPE    = 3'd0;
    localparam logic [2:0] CFG_PHASE_INC    = 3'd1;
    localparam logic [2:0] CFG_SYNC_INC     = 3'd2;
    localparam logic [2:0] CFG_SAW_GAIN     = 3'd3;
    localparam logic [2:0] CFG_SHAPE_GAIN   = 3'd4;
    localparam logic [2:0] CFG_PULSE_GAIN   = 3'd5;
    localparam logic [2:0] CFG_PULSE_OFFSET = 3'd6;
    localparam logic [2:0] CFG_FM_DEPTH     = 3'd7;

    localparam logic [1:0] WAVE_SINE   = 2'd0;
    localparam logic [1:0] WAVE_SQUARE = 2'd1;
    localparam logic [1:0] WAVE_TRI    = 2'd2;

    typedef struct packed {
        logic [1:0]         wave_type;
        logic [31:0]        phase_inc;
        logic [31:0]        sync_inc;
        logic signed [15:0] saw_gain;
        logic signed [15:0] shape_gain;
        logic signed [15:0] pulse_gain;
        logic [14:0]        pulse_offset;
        logic signed [21:0] fm_depth;
    } t_cfg;

    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic signed [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                done;
        logic signed [63:0]  q;
        logic signed [127:0] p;
    } t_mul_rsp;

    typedef struct packed {
        logic         start;
        logic [127:0] num;
        logic [63:0]  den;
    } t_div_req;

    typedef struct packed {
        logic         done;
        logic [127:0] quo;
    } t_div_rsp;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

endpackage

// ===== hw/rtl/dpw_mul.sv =====
// Iterative 64x64 signed multiplier built on one 32x32 unit, with Q3.60 rounding.
module dpw_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dpw_pkg::t_mul_req i_req,
    output dpw_pkg::t_mul_rsp o_rsp
);
    import dpw_pkg::*;

    logic               r_busy;
    logic               r_fin;
    logic [1:0]         r_cnt;
    logic [63:0]        r_am;
    logic [63:0]        r_bm;
    logic               r_neg;
    logic [127:0]       r_acc;
    logic               r_done;
    logic signed [63:0] r_q;
    logic [127:0]       r_p;

    logic [31:0]  pa;
    logic [31:0]  pb;
    logic [63:0]  pp;
    logic [1:0]   lvl;
    logic [127:0] shifted;
    logic [127:0] rnd;
    logic [63:0]  m;

    assign pa      = r_cnt[0] ? r_am[63:32] : r_am[31:0];
    assign pb      = r_cnt[1] ? r_bm[63:32] : r_bm[31:0];
    assign pp      = pa * pb;
    assign lvl     = {1'b0, r_cnt[0]} + {1'b0, r_cnt[1]};
    assign shifted = {64'b0, pp} << {lvl, 5'd0};
    assign rnd     = r_acc + {68'b0, 1'b1, 59'b0};
    assign m       = (rnd[127:123] != 5'd0) ? 64'h7FFF_FFFF_FFFF_FFFF : rnd[123:60];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 2'd0;
                r_acc  <= '0;
                r_am   <= mag64(i_req.a);
                r_bm   <= mag64(i_req.b);
                r_neg  <= i_req.a[63] ^ i_req.b[63];
            end else if (r_busy) begin
                r_acc <= r_acc + shifted;
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
                r_q    <= r_neg ? -$signed(m) : $signed(m);
                r_p    <= r_neg ? -r_acc : r_acc;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;
    assign o_rsp.p    = $signed(r_p);

endmodule

// ===== hw/rtl/dpw_div.sv =====
// Restoring divider, 128-bit dividend over 64-bit divisor, one quotient bit per cycle.
module dpw_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dpw_pkg::t_div_req i_req,
    output dpw_pkg::t_div_rsp o_rsp
);
    import dpw_pkg::*;

    logic         r_busy;
    logic [6:0]   r_cnt;
    logic [127:0] r_num;
    logic [63:0]  r_den;
    logic [63:0]  r_rem;
    logic [127:0] r_quo;
    logic         r_done;

    logic [63:0] rs;
    logic        ge;

    assign rs = {r_rem[62:0], r_num[127]};
    assign ge = r_rem[63] || (rs >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_rem <= ge ? rs - r_den : rs;
                r_quo <= {r_quo[126:0], ge};
                r_num <= {r_num[126:0], 1'b0};
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd127) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

// ===== hw/rtl/dpw_ctrl.sv =====
// Sequencer, phase state and datapath registers driving the shared multiplier and divider.
module dpw_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dpw_pkg::t_cfg      i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_modulator,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [23:0] o_sample,
    output dpw_pkg::t_mul_req  o_mul_req,
    input  dpw_pkg::t_mul_rsp  i_mul_rsp,
    output dpw_pkg::t_div_req  o_div_req,
    input  dpw_pkg::t_div_rsp  i_div_rsp
);
    import dpw_pkg::*;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_FM   = 5'd1;
    localparam logic [4:0] ST_PH   = 5'd2;
    localparam logic [4:0] ST_P2   = 5'd3;
    localparam logic [4:0] ST_P3   = 5'd4;
    localparam logic [4:0] ST_SAW  = 5'd5;
    localparam logic [4:0] ST_SH1  = 5'd6;
    localparam logic [4:0] ST_SH2  = 5'd7;
    localparam logic [4:0] ST_SH3  = 5'd8;
    localparam logic [4:0] ST_PW1  = 5'd9;
    localparam logic [4:0] ST_PW2  = 5'd10;
    localparam logic [4:0] ST_PUL  = 5'd11;
    localparam logic [4:0] ST_G0   = 5'd12;
    localparam logic [4:0] ST_G1   = 5'd13;
    localparam logic [4:0] ST_G2   = 5'd14;
    localparam logic [4:0] ST_SQ   = 5'd15;
    localparam logic [4:0] ST_DIV  = 5'd16;
    localparam logic [4:0] ST_OUT  = 5'd17;
    localparam logic [4:0] ST_RSM  = 5'd18;
    localparam logic [4:0] ST_RSD  = 5'd19;

    logic [4:0]          r_state;
    logic                r_issued;
    logic signed [15:0]  r_mod;
    logic [31:0]         r_ph;
    logic [1:0]          r_k;
    logic signed [63:0]  r_p;
    logic signed [63:0]  r_p2;
    logic signed [63:0]  r_p3;
    logic signed [63:0]  r_t;
    logic signed [63:0]  r_tp;
    logic signed [63:0]  r_pw;
    logic signed [63:0]  r_inner;
    logic signed [63:0]  r_dsaw;
    logic signed [63:0]  r_dshp;
    logic signed [63:0]  r_dpul;
    logic signed [127:0] r_acc;
    logic [63:0]         r_den;
    logic [23:0]         r_res;
    logic                r_out_valid;
    logic signed [23:0]  r_sample;
    logic [31:0]         r_main;
    logic [31:0]         r_sync;
    logic                r_toggle;

    logic                mul_op;
    logic signed [63:0]  mul_a;
    logic signed [63:0]  mul_b;
    logic signed [63:0]  s_sel;
    logic signed [63:0]  p_new;
    logic signed [63:0]  tp_raw;
    logic signed [63:0]  pw_raw;
    logic signed [63:0]  tp_abs;
    logic signed [63:0]  qv;
    logic signed [63:0]  d_add;
    logic [127:0]        acc_mag;
    logic [127:0]        quo;
    logic [23:0]         sat;
    logic [32:0]         main_sum;
    logic                can_load;

    assign p_new   = {{3{~r_ph[31]}}, ~r_ph[31], r_ph[30:0], 29'b0};
    assign tp_raw  = r_p + Q_HALF;
    assign pw_raw  = r_p + {3'b0, i_cfg.pulse_offset, 46'b0};
    assign tp_abs  = r_tp[63] ? -r_tp : r_tp;
    assign s_sel   = r_p[63] ? r_t : -r_t;
    assign qv      = i_mul_rsp.q;
    // second difference weights: +1, -2, +1 over the three phases
    assign d_add   = (r_k == 2'd1) ? -(qv <<< 1) : qv;
    assign acc_mag = r_acc[127] ? 128'(-r_acc) : 128'(r_acc);
    assign quo     = i_div_rsp.quo;
    assign main_sum = {1'b0, r_main} + {1'b0, i_cfg.phase_inc};
    assign can_load = !r_out_valid || !i_out_stall;

    always_comb begin
        if (r_acc[127]) begin
            sat = (quo[127:64] != 64'd0 || quo[63:0] > 64'd8388608) ?
                  24'h800000 : 24'(-quo[23:0]);
        end else begin
            sat = (quo[127:23] != '0) ? 24'h7FFFFF : quo[23:0];
        end
    end

    always_comb begin
        mul_op = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (r_state)
            ST_FM: begin
                mul_a = {{42{i_cfg.fm_depth[21]}}, i_cfg.fm_depth};
                mul_b = {{48{r_mod[15]}}, r_mod};
            end
            ST_P2: begin
                mul_a = r_p;
                mul_b = r_p;
            end
            ST_P3: begin
                mul_a = r_p2;
                mul_b = r_p;
            end
            ST_SAW: begin
                mul_a = r_p3 - r_p;
                mul_b = Q_SIXTH;
            end
            ST_SH1: begin
                case (i_cfg.wave_type)
                    WAVE_SINE: begin
                        mul_a = r_p3;
                        mul_b = r_p;
                    end
                    WAVE_SQUARE: begin
                        mul_a = (r_p[63] ? r_p2 : -r_p2) + r_p;
                        mul_b = Q_HALF;
                    end
                    default: begin
                        mul_a = r_tp;
                        mul_b = r_tp;
                    end
                endcase
            end
            ST_SH2: begin
                if (i_cfg.wave_type == WAVE_SINE) begin
                    mul_a = -(s_sel + (r_p3 <<< 1) - r_p);
                    mul_b = Q_THIRD;
                end else begin
                    mul_a = r_t;
                    mul_b = r_inner;
                end
            end
            ST_SH3: begin
                mul_a = (Q_ONE <<< 1) + r_t;
                mul_b = Q_SIXTH;
            end
            ST_PW1: begin
                mul_a = r_pw;
                mul_b = r_pw;
            end
            ST_PW2: begin
                mul_a = r_t;
                mul_b = r_pw;
            end
            ST_PUL: begin
                mul_a = r_t - r_pw;
                mul_b = Q_SIXTH;
            end
            ST_G0: begin
                mul_a = {{48{i_cfg.saw_gain[15]}}, i_cfg.saw_gain};
                mul_b = r_dsaw;
            end
            ST_G1: begin
                mul_a = {{48{i_cfg.shape_gain[15]}}, i_cfg.shape_gain};
                mul_b = r_dshp;
            end
            ST_G2: begin
                mul_a = {{48{i_cfg.pulse_gain[15]}}, i_cfg.pulse_gain};
                mul_b = r_dpul - r_dsaw;
            end
            ST_SQ: begin
                mul_a = {32'b0, i_cfg.sync_inc};
                mul_b = {32'b0, i_cfg.sync_inc};
            end
            ST_RSM: begin
                mul_a = {32'b0, r_main};
                mul_b = {32'b0, i_cfg.sync_inc};
            end
            default: mul_op = 1'b0;
        endcase
    end

    assign o_mul_req.start = mul_op && !r_issued;
    assign o_mul_req.a     = mul_a;
    assign o_mul_req.b     = mul_b;

    assign o_div_req.start = (r_state == ST_DIV || r_state == ST_RSD) && !r_issued;
    assign o_div_req.num   = (r_state == ST_DIV) ? {acc_mag[119:0], 8'b0} : 128'(r_acc);
    assign o_div_req.den   = (r_state == ST_DIV) ? r_den : {32'b0, i_cfg.phase_inc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
            r_main      <= '0;
            r_sync      <= '0;
            r_toggle    <= 1'b0;
            r_k         <= 2'd0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_mul_req.start || o_div_req.start) begin
                r_issued <= 1'b1;
            end
            if (i_mul_rsp.done || i_div_rsp.done) begin
                r_issued <= 1'b0;
            end
            if (r_state == ST_P2) begin
                r_tp <= (tp_raw > Q_ONE) ? tp_raw - (Q_ONE <<< 1) : tp_raw;
                r_pw <= (pw_raw > Q_ONE) ? pw_raw - (Q_ONE <<< 1) : pw_raw;
            end
            if (r_state == ST_P3) begin
                r_inner <= (Q_ONE * 3) - (tp_abs <<< 1);
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_mod   <= i_modulator;
                        r_dsaw  <= '0;
                        r_dshp  <= '0;
                        r_dpul  <= '0;
                        r_state <= ST_FM;
                    end
                end
                ST_FM: begin
                    if (i_mul_rsp.done) begin
                        r_ph    <= r_sync + {i_mul_rsp.p[30:0], 1'b0};
                        r_k     <= 2'd0;
                        r_state <= ST_PH;
                    end
                end
                ST_PH: begin
                    r_p     <= p_new;
                    r_state <= ST_P2;
                end
                ST_P2: begin
                    if (i_mul_rsp.done) begin
                        r_p2    <= qv;
                        r_state <= ST_P3;
                    end
                end
                ST_P3: begin
                    if (i_mul_rsp.done) begin
                        r_p3    <= qv;
                        r_state <= ST_SAW;
                    end
                end
                ST_SAW: begin
                    if (i_mul_rsp.done) begin
                        r_dsaw <= r_dsaw + d_add;
                        // the unused fourth code has no shape generator
                        if (i_cfg.wave_type != WAVE_SINE && i_cfg.wave_type != WAVE_SQUARE &&
                            i_cfg.wave_type != WAVE_TRI) begin
                            r_state <= ST_PW1;
                        end else begin
                            r_state <= ST_SH1;
                        end
                    end
                end
                ST_SH1: begin
                    if (i_mul_rsp.done) begin
                        if (i_cfg.wave_type == WAVE_SQUARE) begin
                            r_dshp  <= r_dshp + d_add;
                            r_state <= ST_PW1;
                        end else begin
                            r_t     <= qv;
                            r_state <= ST_SH2;
                        end
                    end
                end
                ST_SH2: begin
                    if (i_mul_rsp.done) begin
                        if (i_cfg.wave_type == WAVE_SINE) begin
                            r_dshp  <= r_dshp + d_add;
                            r_state <= ST_PW1;
                        end else begin
                            r_t     <= qv;
                            r_state <= ST_SH3;
                        end
                    end
                end
                ST_SH3: begin
                    if (i_mul_rsp.done) begin
                        r_dshp  <= r_dshp + d_add;
                        r_state <= ST_PW1;
                    end
                end
                ST_PW1: begin
                    if (i_mul_rsp.done) begin
                        r_t     <= qv;
                        r_state <= ST_PW2;
                    end
                end
                ST_PW2: begin
                    if (i_mul_rsp.done) begin
                        r_t     <= qv;
                        r_state <= ST_PUL;
                    end
                end
                ST_PUL: begin
                    if (i_mul_rsp.done) begin
                        r_dpul <= r_dpul + d_add;
                        if (r_k == 2'd2) begin
                            r_state <= ST_G0;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_ph    <= r_ph - i_cfg.sync_inc;
                            r_state <= ST_PH;
                        end
                    end
                end
                ST_G0: begin
                    if (i_mul_rsp.done) begin
                        r_acc   <= i_mul_rsp.p;
                        r_state <= ST_G1;
                    end
                end
                ST_G1: begin
                    if (i_mul_rsp.done) begin
                        r_acc   <= r_acc + i_mul_rsp.p;
                        r_state <= ST_G2;
                    end
                end
                ST_G2: begin
                    if (i_mul_rsp.done) begin
                        r_acc <= r_acc + i_mul_rsp.p;
                        if (i_cfg.sync_inc == 32'd0) begin
                            r_res   <= '0;
                            r_state <= ST_OUT;
                        end else begin
                            r_state <= ST_SQ;
                        end
                    end
                end
                ST_SQ: begin
                    if (i_mul_rsp.done) begin
                        r_den   <= i_mul_rsp.p[63:0];
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (i_div_rsp.done) begin
                        r_res   <= sat;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (can_load) begin
                        r_sample    <= $signed(r_res);
                        r_out_valid <= 1'b1;
                        r_sync      <= r_sync + i_cfg.sync_inc;
                        r_main      <= main_sum[31:0];
                        r_state     <= ST_IDLE;
                        if (main_sum[32]) begin
                            r_toggle <= ~r_toggle;
                            if (r_toggle) begin
                                r_state <= ST_RSM;
                            end
                        end
                    end
                end
                ST_RSM: begin
                    if (i_mul_rsp.done) begin
                        r_acc   <= i_mul_rsp.p;
                        r_state <= ST_RSD;
                    end
                end
                ST_RSD: begin
                    if (i_div_rsp.done) begin
                        r_sync  <= quo[31:0];
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

endmodule

// ===== hw/rtl/dpw_alias_suppressed_oscillator.sv =====
// Alias-suppressed cubic polynomial oscillator: configuration registers and unit wiring.
//
// Input channel: one signed FM modulator sample per request (i_in_valid / o_in_stall).
// Output channel: one saturated signed Q3.20 sample per request (o_out_valid / i_out_stall).
// Configuration: i_cfg_valid / o_cfg_ready with a register index and data; write it only
// while the block is idle. Ready is always high.
// Computation: the work per request is set by the selected waveform. 23 to 32 rounded
// 64-bit products are formed on one 32x32 multiplier, the phase is set up before each of
// the three phases, and the final scaling runs through a restoring divider. A zero sync
// increment skips the squaring and the division. On every second main-phase wrap the
// synced phase is rescaled by one more product and one more division.
// Throughput: one request at a time; o_in_stall stays high for the whole computation.
// The next request can be taken once the sample is loaded, or once the rescale is done
// when one runs. The finished sample sits in an output register, so a stalled
// receiver does not block the next request until that one's result is ready; the
// sequencer then waits.
// Reset (synchronous, active low) clears phases, the toggle, the output valid and
// loads the register defaults.
module dpw_alias_suppressed_oscillator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_modulator,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [23:0] o_sample,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import dpw_pkg::*;

    t_cfg     r_cfg;
    t_mul_req mul_req;
    t_mul_rsp mul_rsp;
    t_div_req div_req;
    t_div_rsp div_rsp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wave_type    <= WAVE_SINE;
            r_cfg.phase_inc    <= 32'd16777216;
            r_cfg.sync_inc     <= 32'd16777216;
            r_cfg.saw_gain     <= 16'sd4096;
            r_cfg.shape_gain   <= '0;
            r_cfg.pulse_gain   <= '0;
            r_cfg.pulse_offset <= 15'd16384;
            r_cfg.fm_depth     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_WAVE_TYPE:    r_cfg.wave_type    <= i_cfg_data[1:0];
                CFG_PHASE_INC:    r_cfg.phase_inc    <= i_cfg_data;
                CFG_SYNC_INC:     r_cfg.sync_inc     <= i_cfg_data;
                CFG_SAW_GAIN:     r_cfg.saw_gain     <= i_cfg_data[15:0];
                CFG_SHAPE_GAIN:   r_cfg.shape_gain   <= i_cfg_data[15:0];
                CFG_PULSE_GAIN:   r_cfg.pulse_gain   <= i_cfg_data[15:0];
                CFG_PULSE_OFFSET: r_cfg.pulse_offset <= i_cfg_data[14:0];
                CFG_FM_DEPTH:     r_cfg.fm_depth     <= i_cfg_data[21:0];
                default: ;
            endcase
        end
    end

    dpw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_modulator (i_modulator),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_sample    (o_sample),
        .o_mul_req   (mul_req),
        .i_mul_rsp   (mul_rsp),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp)
    );

    dpw_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    dpw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

endmodule

// ===== hw/rtl/dpw_chk.sv =====
// Port-level checker for the oscillator, bound to the top level.
module dpw_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic signed [15:0] i_modulator,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [23:0] o_sample
);

    // a request keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // a result never appears right after a request
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !$rose(o_out_valid))
        else $error("result too early");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_modulator)))
        else $error("stalled request changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_sample)))
        else $error("stalled output changed");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("reset did not clear handshake");

endmodule

bind dpw_alias_suppressed_oscillator dpw_chk u_chk (.*);

// ===== verif/dpw_alias_suppressed_oscillator_tb.sv =====
// Testbench of the alias-suppressed polynomial oscillator: directed table, random phases, predictor.
`timescale 1ns / 1ps

module dpw_alias_suppressed_oscillator_tb;
    import dpw_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 400;
    localparam int HOLD_CYCLES    = 1500;
    localparam int ITEMS_PER_SET  = 150;
    localparam int NUM_SETS       = 8;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [15:0] i_modulator;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [23:0] o_sample;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    dpw_alias_suppressed_oscillator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_modulator (i_modulator),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_sample    (o_sample),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Predictor copy of registers and state
    logic [1:0]         osc_wave;
    logic [31:0]        osc_pinc;
    logic [31:0]        osc_sinc;
    logic signed [63:0] osc_saw_g;
    logic signed [63:0] osc_shape_g;
    logic signed [63:0] osc_pulse_g;
    logic [14:0]        osc_pofs;
    logic signed [63:0] osc_fm;
    logic [31:0]        osc_main_ph;
    logic [31:0]        osc_sync_ph;
    logic               osc_toggle;

    logic signed [23:0] sample_q[$];
    int                 errors;
    int                 idle_in;
    int                 idle_out;
    int                 hold_req;
    int                 hold_seen;
    int                 hold_left;
    int                 quiet_cycles;

    typedef struct {
        bit                 has_cfg;
        logic [2:0]         idx;
        logic [31:0]        data;
        bit                 send;
        logic signed [15:0] mod;
        bit                 fixed;
        logic signed [23:0] val;
    } t_row;

    t_row stim_rows[$];

    task automatic report_err(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic logic signed [63:0] qmul_rnd(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [63:0]  m;
        logic [127:0] p;
        ma = a[63] ? 64'(-a) : 64'(a);
        mb = b[63] ? 64'(-b) : 64'(b);
        p = {64'd0, ma} * {64'd0, mb} + (128'd1 << 59);
        m = p[123:60];
        if (|p[127:123]) m = 64'h7FFF_FFFF_FFFF_FFFF;
        return (a[63] ^ b[63]) ? -$signed(m) : $signed(m);
    endfunction

    function automatic void poly_gen(input logic [31:0] ph, output logic signed [63:0] saw,
                                     output logic signed [63:0] shp,
                                     output logic signed [63:0] pul);
        logic signed [63:0] p;
        logic signed [63:0] p2;
        logic signed [63:0] p3;
        logic signed [63:0] p4;
        logic signed [63:0] s;
        logic signed [63:0] tp;
        logic signed [63:0] tabs;
        logic signed [63:0] inner;
        logic signed [63:0] pw;
        logic signed [63:0] pw3;
        logic signed [63:0] ofs;
        p = {32'd0, ph};
        p = (p - 64'sd2147483648) <<< 29;
        p2 = qmul_rnd(p, p);
        p3 = qmul_rnd(p2, p);
        saw = qmul_rnd(p3 - p, Q_SIXTH);
        if (osc_wave == WAVE_SINE) begin
            p4 = qmul_rnd(p3, p);
            s = p[63] ? p4 : -p4;
            shp = qmul_rnd(-(s + 2 * p3 - p), Q_THIRD);
        end else if (osc_wave == WAVE_SQUARE) begin
            shp = qmul_rnd((p[63] ? p2 : -p2) + p, Q_HALF);
        end else if (osc_wave == WAVE_TRI) begin
            tp = p + Q_HALF;
            if (tp > Q_ONE) tp = tp - 2 * Q_ONE;
            tabs = tp[63] ? -tp : tp;
            inner = 3 * Q_ONE - 2 * tabs;
            shp = qmul_rnd(2 * Q_ONE + qmul_rnd(qmul_rnd(tp, tp), inner), Q_SIXTH);
        end else begin
            shp = 0;
        end
        ofs = {49'd0, osc_pofs};
        ofs = ofs <<< 46;
        pw = p + ofs;
        if (pw > Q_ONE) pw = pw - 2 * Q_ONE;
        pw3 = qmul_rnd(qmul_rnd(pw, pw), pw);
        pul = qmul_rnd(pw3 - pw, Q_SIXTH);
    endfunction

    // Compute one output sample and advance the phases
    function automatic logic signed [23:0] osc_next(input logic signed [15:0] mod);
        logic signed [63:0]  modv;
        logic signed [63:0]  shift;
        logic [31:0]         pfm;
        logic [31:0]         ph;
        logic signed [63:0]  sw[3];
        logic signed [63:0]  sh[3];
        logic signed [63:0]  pu[3];
        logic signed [127:0] g1;
        logic signed [127:0] g2;
        logic signed [127:0] g3;
        logic signed [127:0] e1;
        logic signed [127:0] e2;
        logic signed [127:0] e3;
        logic signed [63:0]  dsaw;
        logic signed [63:0]  dshp;
        logic signed [63:0]  dpul;
        logic signed [127:0] acc;
        logic [127:0]        amag;
        logic [127:0]        num;
        logic [127:0]        quo;
        logic [63:0]         den;
        logic [32:0]         sum;
        logic [63:0]         prod;
        logic signed [23:0]  res;
        modv = mod;
        shift = osc_fm * modv * 64'sd2;
        pfm = osc_sync_ph + shift[31:0];
        for (int k = 0; k < 3; k++) begin
            ph = pfm - 32'(32'(k) * osc_sinc);
            poly_gen(ph, sw[k], sh[k], pu[k]);
        end
        dsaw = sw[0] + sw[2] - 2 * sw[1];
        dshp = sh[0] + sh[2] - 2 * sh[1];
        dpul = pu[0] + pu[2] - 2 * pu[1];
        g1 = osc_saw_g;
        g2 = osc_shape_g;
        g3 = osc_pulse_g;
        e1 = dsaw;
        e2 = dshp;
        e3 = dpul - dsaw;
        acc = g1 * e1 + g2 * e2 + g3 * e3;
        res = '0;
        if (osc_sinc != 0) begin
            amag = acc[127] ? 128'(-acc) : 128'(acc);
            num = {amag[119:0], 8'd0};
            den = {32'd0, osc_sinc} * {32'd0, osc_sinc};
            quo = num / {64'd0, den};
            if (acc[127])
                res = (quo > 128'd8388608) ? -24'sd8388608 : -$signed(quo[23:0]);
            else
                res = (quo > 128'd8388607) ? 24'sd8388607 : $signed(quo[23:0]);
        end
        osc_sync_ph = osc_sync_ph + osc_sinc;
        sum = {1'b0, osc_main_ph} + {1'b0, osc_pinc};
        osc_main_ph = sum[31:0];
        if (sum[32]) begin
            if (osc_toggle) begin
                prod = {32'd0, osc_main_ph} * {32'd0, osc_sinc};
                osc_sync_ph = 32'(prod / {32'd0, osc_pinc});
            end
            osc_toggle = ~osc_toggle;
        end
        return res;
    endfunction

    function automatic void osc_reset();
        osc_wave = WAVE_SINE;
        osc_pinc = 32'd16777216;
        osc_sinc = 32'd16777216;
        osc_saw_g = 4096;
        osc_shape_g = 0;
        osc_pulse_g = 0;
        osc_pofs = 15'd16384;
        osc_fm = 0;
        osc_main_ph = '0;
        osc_sync_ph = '0;
        osc_toggle = 1'b0;
    endfunction

    function automatic void osc_write(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            CFG_WAVE_TYPE:    osc_wave = data[1:0];
            CFG_PHASE_INC:    osc_pinc = data;
            CFG_SYNC_INC:     osc_sinc = data;
            CFG_SAW_GAIN:     osc_saw_g = $signed(data[15:0]);
            CFG_SHAPE_GAIN:   osc_shape_g = $signed(data[15:0]);
            CFG_PULSE_GAIN:   osc_pulse_g = $signed(data[15:0]);
            CFG_PULSE_OFFSET: osc_pofs = data[14:0];
            CFG_FM_DEPTH:     osc_fm = $signed(data[21:0]);
            default: ;
        endcase
    endfunction

    // Called at a falling edge; drops valid after acceptance, then returns at a falling edge
    task automatic send_req(input logic signed [15:0] mod, input bit fixed,
                            input logic signed [23:0] val);
        logic signed [23:0] pred;
        while ($urandom_range(99) < idle_in) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_modulator <= mod;
        do @(posedge i_clk); while (o_in_stall);
        pred = osc_next(mod);
        sample_q.push_back(fixed ? val : pred);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        osc_write(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Drop input valid, drain all expected samples, then let the block go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sample_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_inc();
        case ($urandom_range(6))
            0: return 32'd0;
            1: return 32'h8000_0000;
            2: return $urandom_range(32'h0000_1000, 1);
            3: return $urandom_range(32'h0100_0000, 32'h0000_1000);
            default: return $urandom_range(32'h8000_0000, 32'h0100_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_gain();
        int g;
        case ($urandom_range(7))
            0: g = 16384;
            1: g = -16384;
            default: g = int'($urandom_range(32768)) - 16384;
        endcase
        return 32'(g);
    endfunction

    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < idle_out);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (sample_q.size() == 0) begin
                report_err($sformatf("unexpected sample %0d", o_sample));
            end else begin
                if (o_sample !== sample_q[0])
                    report_err($sformatf("sample %0d, predicted %0d", o_sample, sample_q[0]));
                void'(sample_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_row row_cfg(input logic [2:0] idx, input logic [31:0] data);
        return '{1'b1, idx, data, 1'b0, 16'sd0, 1'b0, 24'sd0};
    endfunction

    function automatic t_row row_item(input logic signed [15:0] mod, input bit fixed,
                                      input logic signed [23:0] val);
        return '{1'b0, 3'd0, 32'd0, 1'b1, mod, fixed, val};
    endfunction

    initial begin
        logic signed [15:0] mod;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_modulator = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        errors = 0;
        hold_req = 0;
        hold_seen = 0;
        hold_left = 0;
        quiet_cycles = 0;
        idle_in = 18;
        idle_out = 54;
        osc_reset();

        // Defaults, FM extremes, every waveform, pulse offsets, wrap rescale, zero sync
        stim_rows.push_back(row_item(16'sd0, 0, 0));
        stim_rows.push_back(row_item(16'sd32767, 0, 0));
        stim_rows.push_back(row_item(-16'sd32768, 0, 0));
        stim_rows.push_back(row_cfg(CFG_FM_DEPTH, 32'h0010_0000));
        stim_rows.push_back(row_item(16'sd32767, 0, 0));
        stim_rows.push_back(row_cfg(CFG_FM_DEPTH, 32'h0030_0000));
        stim_rows.push_back(row_item(-16'sd32768, 0, 0));
        stim_rows.push_back(row_cfg(CFG_SHAPE_GAIN, 32'h0000_4000));
        stim_rows.push_back(row_cfg(CFG_WAVE_TYPE, {30'd0, WAVE_SQUARE}));
        stim_rows.push_back(row_item(16'sd1000, 0, 0));
        stim_rows.push_back(row_cfg(CFG_WAVE_TYPE, {30'd0, WAVE_TRI}));
        stim_rows.push_back(row_item(16'sd1000, 0, 0));
        stim_rows.push_back(row_cfg(CFG_WAVE_TYPE, 32'd3));
        stim_rows.push_back(row_item(-16'sd1000, 0, 0));
        stim_rows.push_back(row_cfg(CFG_PULSE_GAIN, 32'h0000_C000));
        stim_rows.push_back(row_cfg(CFG_PULSE_OFFSET, 32'd328));
        stim_rows.push_back(row_item(16'sd0, 0, 0));
        stim_rows.push_back(row_cfg(CFG_PULSE_OFFSET, 32'd32767));
        stim_rows.push_back(row_item(16'sd0, 0, 0));
        stim_rows.push_back(row_cfg(CFG_PHASE_INC, 32'h8000_0000));
        stim_rows.push_back(row_item(16'sd5, 0, 0));
        stim_rows.push_back(row_item(16'sd5, 0, 0));
        stim_rows.push_back(row_item(16'sd5, 0, 0));
        stim_rows.push_back(row_cfg(CFG_SYNC_INC, 32'd0));
        stim_rows.push_back(row_item(16'sd32767, 1, 0));
        stim_rows.push_back(row_item(-16'sd32768, 1, 0));
        stim_rows.push_back(row_cfg(CFG_SYNC_INC, 32'd1));
        stim_rows.push_back(row_cfg(CFG_SAW_GAIN, 32'h0000_4000));
        stim_rows.push_back(row_item(16'sd0, 0, 0));
        stim_rows.push_back(row_cfg(CFG_PHASE_INC, 32'd0));
        stim_rows.push_back(row_item(16'sd0, 0, 0));

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (stim_rows[r]) begin
            if (stim_rows[r].has_cfg) begin
                settle();
                cfg_write(stim_rows[r].idx, stim_rows[r].data);
            end
            if (stim_rows[r].send)
                send_req(stim_rows[r].mod, stim_rows[r].fixed, stim_rows[r].val);
        end

        for (int set = 0; set < NUM_SETS; set++) begin
            settle();
            if (set < 3) begin
                idle_in = 18;
                idle_out = 54;
            end else if (set < 6) begin
                idle_in = 54;
                idle_out = 18;
            end else begin
                idle_in = 0;
                idle_out = 0;
            end
            cfg_write(CFG_WAVE_TYPE, $urandom_range(3));
            cfg_write(CFG_PHASE_INC, rand_inc());
            cfg_write(CFG_SYNC_INC, (set == 0) ? 32'h8000_0000 : rand_inc());
            cfg_write(CFG_SAW_GAIN, rand_gain());
            cfg_write(CFG_SHAPE_GAIN, rand_gain());
            cfg_write(CFG_PULSE_GAIN, rand_gain());
            case ($urandom_range(5))
                0: cfg_write(CFG_PULSE_OFFSET, 32'd0);
                1: cfg_write(CFG_PULSE_OFFSET, 32'd32767);
                default: cfg_write(CFG_PULSE_OFFSET, $urandom_range(32440, 328));
            endcase
            cfg_write(CFG_FM_DEPTH, 32'(int'($urandom_range(2097152)) - 1048576));
            if (set == 1) hold_req++;
            for (int n = 0; n < ITEMS_PER_SET; n++) begin
                case ($urandom_range(9))
                    0: mod = 16'sh7FFF;
                    1: mod = 16'sh8000;
                    2: mod = 16'sd0;
                    default: mod = $signed(16'($urandom()));
                endcase
                send_req(mod, 0, 0);
            end
        end

        settle();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== dpw_alias_suppressed_oscillator.f =====
hw/rtl/dpw_pkg.sv
hw/rtl/dpw_mul.sv
hw/rtl/dpw_div.sv
hw/rtl/dpw_ctrl.sv
hw/rtl/dpw_alias_suppressed_oscillator.sv
hw/rtl/dpw_chk.sv
verif/dpw_alias_suppressed_oscillator_tb.sv
